// File: src/dos_pkg.sv
`timescale 1ns / 1ps

package dos_pkg;

  // Board storage and field widths
  localparam int BOARDS = 4;
  localparam int WORD_W = 24;
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef logic [WORD_W-1:0] word_t;

  // Action codes
  localparam logic [3:0] ACT_CMD    = 4'd0;
  localparam logic [3:0] ACT_FORCE  = 4'd1;
  localparam logic [3:0] ACT_FEN    = 4'd2;
  localparam logic [3:0] ACT_RMASK  = 4'd3;
  localparam logic [3:0] ACT_DRIVE  = 4'd4;
  localparam logic [3:0] ACT_SAMPLE = 4'd5;
  localparam logic [3:0] ACT_LED    = 4'd6;
  localparam logic [3:0] ACT_QUERY  = 4'd7;
  localparam logic [3:0] ACT_BRESET = 4'd8;

  // Forcing settings and reported forcing codes
  localparam logic [1:0] SET_FORCE_LOW  = 2'd0;
  localparam logic [1:0] SET_FORCE_HIGH = 2'd1;
  localparam logic [1:0] FRC_NONE = 2'd0;
  localparam logic [1:0] FRC_LOW  = 2'd1;
  localparam logic [1:0] FRC_HIGH = 2'd2;

  // Bit positions and masks
  localparam word_t CHAN_MASK = 24'h7FFFF0;
  localparam word_t LED_BIT   = 24'h000001;
  localparam word_t PWR_BIT   = 24'h000004;
  localparam logic [4:0] CH_FIRST   = 5'd1;
  localparam logic [4:0] CH_LAST    = 5'd19;
  localparam logic [4:0] CH_BIT_OFS = 5'd3;

  // Status bits
  localparam logic [1:0] ST_SUPPLY = 2'b01;
  localparam logic [1:0] ST_CHFAIL = 2'b10;

  // Classified item passed from front to back
  typedef struct packed {
    logic [3:0] action;
    logic [1:0] board;
    word_t      chmask;
    logic [1:0] setting;
    word_t      rmask;
    word_t      readback;
    logic       err;
  } dos_item_t;

endpackage

// File: src/dos_front.sv
`timescale 1ns / 1ps

module dos_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [3:0]        action,
  input  logic [1:0]        board,
  input  logic [4:0]        channel,
  input  logic [1:0]        setting,
  input  logic [31:0]       reset_mask,
  input  logic [23:0]       readback,
  input  logic              board_count_we,
  input  logic [2:0]        board_count_wdata,
  input  logic              pop,
  output logic              busy,
  output logic              head_valid,
  output dos_pkg::dos_item_t head
);
  import dos_pkg::*;

  logic [2:0]       board_count;
  dos_item_t        q [QDEPTH];
  logic [QPW-1:0]   wptr, rptr;
  logic [QCW-1:0]   count, count_next;
  dos_item_t        item;
  logic             push;
  logic [4:0]       bitpos;

  // Board count register
  always_ff @(posedge clk) begin
    if (rst) begin
      board_count <= 3'd0;
    end else if (board_count_we) begin
      board_count <= board_count_wdata;
    end
  end

  // Classify the incoming item
  always_comb begin
    bitpos        = channel + CH_BIT_OFS;
    item.action   = action;
    item.board    = board;
    item.setting  = setting;
    item.rmask    = reset_mask[WORD_W-1:0] & CHAN_MASK;
    item.readback = readback;
    item.chmask   = (channel >= CH_FIRST && channel <= CH_LAST) ?
                    (word_t'(1) << bitpos) : '0;
    item.err      = ({1'b0, board} >= board_count) || (32'(board) >= BOARDS);
  end

  assign busy       = (count == QCW'(QDEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = q[rptr];

  // Item queue between front and back
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCW'(1);
    end else if (!push && pop) begin
      count_next = count - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wptr <= wptr + QPW'(1);
      end
      if (pop) begin
        rptr <= rptr + QPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= item;
    end
  end

endmodule

// File: src/dos_back.sv
`timescale 1ns / 1ps

module dos_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  dos_pkg::dos_item_t head,
  output logic               pop,
  output logic               done,
  output logic               drive_strobe,
  output logic [23:0]        out_word,
  output logic               last,
  output logic               board_error,
  output logic [1:0]         status,
  output logic [23:0]        filtered_input,
  output logic [23:0]        fail_low_mask,
  output logic [23:0]        fail_high_mask,
  output logic               chan_command,
  output logic [1:0]         chan_forcing,
  output logic               chan_fail_enable
);
  import dos_pkg::*;

  // Per-board state
  word_t      ii  [BOARDS];
  word_t      oi  [BOARDS];
  word_t      cb  [BOARDS];
  word_t      fl  [BOARDS];
  word_t      fh  [BOARDS];
  word_t      fal [BOARDS];
  word_t      fah [BOARDS];
  word_t      fe  [BOARDS];
  word_t      pr  [BOARDS];
  word_t      prr [BOARDS];
  word_t      pfh [BOARDS];
  logic [1:0] st  [BOARDS];

  logic       phase;
  logic [1:0] b;
  word_t      m;
  word_t      ii_n, oi_n, cb_n, fl_n, fh_n, fal_n, fah_n, fe_n, pr_n, prr_n, pfh_n;
  word_t      f1;
  logic [1:0] st_n;
  logic       strobe_n, last_n, upd, is_brst;

  assign b       = head.board;
  assign m       = head.chmask;
  assign is_brst = (head.action == ACT_BRESET) && !head.err;
  // a board reset holds the queue head for its second result
  assign pop     = head_valid && !(is_brst && !phase);
  assign upd     = head_valid && !head.err;

  // Execute the action on the addressed board
  always_comb begin
    ii_n  = ii[b];
    oi_n  = oi[b];
    cb_n  = cb[b];
    fl_n  = fl[b];
    fh_n  = fh[b];
    fal_n = fal[b];
    fah_n = fah[b];
    fe_n  = fe[b];
    pr_n  = pr[b];
    prr_n = prr[b];
    pfh_n = pfh[b];
    st_n  = st[b];
    f1    = '0;
    strobe_n = 1'b0;
    last_n   = 1'b1;
    case (head.action)
      ACT_CMD: begin
        if (m != '0) cb_n = (head.setting != 2'd0) ? (cb_n | m) : (cb_n & ~m);
      end
      ACT_FORCE: begin
        if (m != '0) begin
          fl_n = (head.setting == SET_FORCE_LOW)  ? (fl_n | m) : (fl_n & ~m);
          fh_n = (head.setting == SET_FORCE_HIGH) ? (fh_n | m) : (fh_n & ~m);
        end
      end
      ACT_FEN: begin
        if (m != '0) fe_n = (head.setting != 2'd0) ? (fe_n | m) : (fe_n & ~m);
      end
      ACT_RMASK: begin
        pr_n  = head.rmask;
        fal_n = fal_n & ~head.rmask;
        fah_n = fah_n & ~head.rmask;
        st_n  = st_n & ~ST_CHFAIL;
      end
      ACT_DRIVE: begin
        oi_n     = ~pr_n & (cb_n | fh_n) & ~fl_n;
        pr_n     = '0;
        strobe_n = 1'b1;
      end
      ACT_SAMPLE: begin
        // two-sample filter: a bit changes only when two samples agree
        ii_n  = (ii_n & (head.readback | prr_n)) | (head.readback & prr_n);
        prr_n = head.readback;
        fal_n = fal_n | (fe_n & ~oi_n & ~ii_n);
        f1    = fe_n & oi_n & ii_n;
        fah_n = (fah_n & (f1 | pfh_n)) | (f1 & pfh_n);
        pfh_n = f1;
        if (fal_n != '0 || fah_n != '0) st_n = st_n | ST_CHFAIL;
        if (ii_n[0]) st_n = st_n | ST_SUPPLY;
      end
      ACT_LED: begin
        cb_n = (head.setting != 2'd0) ? (cb_n | LED_BIT) : (cb_n & ~LED_BIT);
      end
      ACT_BRESET: begin
        strobe_n = 1'b1;
        if (!phase) begin
          // power off with all channels held in reset
          ii_n   = '0;
          fal_n  = fal_n & ~CHAN_MASK;
          fah_n  = fah_n & ~CHAN_MASK;
          st_n   = st_n & ~ST_CHFAIL;
          cb_n   = cb_n | PWR_BIT;
          oi_n   = ~CHAN_MASK & (cb_n | fh_n) & ~fl_n;
          pr_n   = '0;
          last_n = 1'b0;
        end else begin
          // power back on
          cb_n = cb_n & ~PWR_BIT;
          oi_n = ~pr_n & (cb_n | fh_n) & ~fl_n;
          pr_n = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // State write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      for (int i = 0; i < BOARDS; i++) begin
        ii[i]  <= '0;
        oi[i]  <= '0;
        cb[i]  <= '0;
        fl[i]  <= '0;
        fh[i]  <= '0;
        fal[i] <= '0;
        fah[i] <= '0;
        fe[i]  <= '0;
        pr[i]  <= '0;
        prr[i] <= '0;
        pfh[i] <= '0;
        st[i]  <= '0;
      end
    end else begin
      if (head_valid) begin
        phase <= is_brst && !phase;
      end
      if (upd) begin
        ii[b]  <= ii_n;
        oi[b]  <= oi_n;
        cb[b]  <= cb_n;
        fl[b]  <= fl_n;
        fh[b]  <= fh_n;
        fal[b] <= fal_n;
        fah[b] <= fah_n;
        fe[b]  <= fe_n;
        pr[b]  <= pr_n;
        prr[b] <= prr_n;
        pfh[b] <= pfh_n;
        st[b]  <= st_n;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid) begin
      if (head.err) begin
        drive_strobe     <= 1'b0;
        out_word         <= '0;
        last             <= 1'b1;
        board_error      <= 1'b1;
        status           <= '0;
        filtered_input   <= '0;
        fail_low_mask    <= '0;
        fail_high_mask   <= '0;
        chan_command     <= 1'b0;
        chan_forcing     <= FRC_NONE;
        chan_fail_enable <= 1'b0;
      end else begin
        drive_strobe     <= strobe_n;
        out_word         <= oi_n;
        last             <= last_n;
        board_error      <= 1'b0;
        status           <= st_n;
        filtered_input   <= ii_n;
        fail_low_mask    <= fal_n;
        fail_high_mask   <= fah_n;
        chan_command     <= ((cb_n & m) != '0);
        chan_forcing     <= ((fh_n & m) != '0) ? FRC_HIGH :
                            (((fl_n & m) != '0) ? FRC_LOW : FRC_NONE);
        chan_fail_enable <= ((fe_n & m) != '0);
      end
    end
  end

endmodule

// File: src/digital_output_supervisor.sv
`timescale 1ns / 1ps
// Supervisor for up to four 24-bit digital output boards.
// Input: an item (action, board, channel, setting, reset_mask, readback) is
//   taken at a clock edge with start high and busy low. A two-entry queue
//   sits between the accepting front and the executing back, so busy rises
//   only when both entries are taken.
// Output: every item gives one result, a board reset on a valid board gives
//   two on consecutive cycles. Each result is shown for one cycle with done
//   high; last marks the final result of an item. drive_strobe asks for
//   out_word to be written to the board.
// Throughput: one item per cycle, set by the single-ported execute stage
//   working on one board entry per cycle; a board reset holds the queue
//   head for its second result, and busy rises when the queue is full.
// Configuration: board_count is written with board_count_we; the user must
//   do so only while idle, which the block does not enforce. Items for
//   boards at or above it come back with board_error set.
// Reset (rst, synchronous): all board images, masks and status clear,
//   board_count is zero and the queue empties. The receiver cannot stall
//   results; they must be taken in the cycle they appear.
module digital_output_supervisor (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  action,
  input  logic [1:0]  board,
  input  logic [4:0]  channel,
  input  logic [1:0]  setting,
  input  logic [31:0] reset_mask,
  input  logic [23:0] readback,
  input  logic        board_count_we,
  input  logic [2:0]  board_count_wdata,
  output logic        done,
  output logic        drive_strobe,
  output logic [23:0] out_word,
  output logic        last,
  output logic        board_error,
  output logic [1:0]  status,
  output logic [23:0] filtered_input,
  output logic [23:0] fail_low_mask,
  output logic [23:0] fail_high_mask,
  output logic        chan_command,
  output logic [1:0]  chan_forcing,
  output logic        chan_fail_enable
);
  import dos_pkg::*;

  dos_item_t head;
  logic      head_valid;
  logic      pop;

  // Accept, classify and queue
  dos_front u_front (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .action            (action),
    .board             (board),
    .channel           (channel),
    .setting           (setting),
    .reset_mask        (reset_mask),
    .readback          (readback),
    .board_count_we    (board_count_we),
    .board_count_wdata (board_count_wdata),
    .pop               (pop),
    .busy              (busy),
    .head_valid        (head_valid),
    .head              (head)
  );

  // Execute and report
  dos_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .done             (done),
    .drive_strobe     (drive_strobe),
    .out_word         (out_word),
    .last             (last),
    .board_error      (board_error),
    .status           (status),
    .filtered_input   (filtered_input),
    .fail_low_mask    (fail_low_mask),
    .fail_high_mask   (fail_high_mask),
    .chan_command     (chan_command),
    .chan_forcing     (chan_forcing),
    .chan_fail_enable (chan_fail_enable)
  );

endmodule

// File: src/dos_checker.sv
`timescale 1ns / 1ps

module dos_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic        drive_strobe,
  input logic [23:0] out_word,
  input logic        last,
  input logic        board_error
);

  // The first result of a board reset is followed at once by its last one
  a_pair: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done && last)
    else $error("board reset pair broken");

  // A non-final result only comes from a board reset, which always drives
  a_first_drives: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> drive_strobe && !board_error)
    else $error("first result of a pair does not drive");

  // A rejected item drives nothing and is a single result
  a_err: assert property (@(posedge clk) disable iff (rst)
    done && board_error |-> !drive_strobe && last && out_word == 24'd0)
    else $error("board error result not clean");

  // Nothing is reported or held off right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !done && !busy)
    else $error("activity after reset");

endmodule

bind digital_output_supervisor dos_checker u_dos_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .done         (done),
  .drive_strobe (drive_strobe),
  .out_word     (out_word),
  .last         (last),
  .board_error  (board_error)
);

// File: tb/tb_digital_output_supervisor.sv
`timescale 1ns / 1ps

module tb_digital_output_supervisor;
  import dos_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_QUOTA = 200;
  localparam logic [3:0] ACT_SPARE_LO = ACT_BRESET + 4'd1;
  localparam logic [3:0] ACT_SPARE_HI = 4'hF;
  localparam logic [31:0] RMASK_ALL = 32'hFFFF_FFFF;

  // One result as seen on the output ports
  typedef struct packed {
    logic       drv;
    word_t      word;
    logic       lst;
    logic       berr;
    logic [1:0] stat;
    word_t      filt;
    word_t      flo;
    word_t      fhi;
    logic       ccmd;
    logic [1:0] cfrc;
    logic       cfen;
  } sup_result_t;

  // Directed stimulus row: either a board_count write or one item
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  cfg;
    logic [3:0]  act;
    logic [1:0]  brd;
    logic [4:0]  ch;
    logic [1:0]  st;
    logic [31:0] rm;
    word_t       rb;
    logic        has_exp;
    sup_result_t exp;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  action;
  logic [1:0]  board;
  logic [4:0]  channel;
  logic [1:0]  setting;
  logic [31:0] reset_mask;
  logic [23:0] readback;
  logic        board_count_we;
  logic [2:0]  board_count_wdata;
  logic        done;
  logic        drive_strobe;
  logic [23:0] out_word;
  logic        last;
  logic        board_error;
  logic [1:0]  status;
  logic [23:0] filtered_input;
  logic [23:0] fail_low_mask;
  logic [23:0] fail_high_mask;
  logic        chan_command;
  logic [1:0]  chan_forcing;
  logic        chan_fail_enable;

  // Typed expectation travelling with the item being offered
  logic        offer_has_exp;
  sup_result_t offer_exp;

  digital_output_supervisor dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .action           (action),
    .board            (board),
    .channel          (channel),
    .setting          (setting),
    .reset_mask       (reset_mask),
    .readback         (readback),
    .board_count_we   (board_count_we),
    .board_count_wdata(board_count_wdata),
    .done             (done),
    .drive_strobe     (drive_strobe),
    .out_word         (out_word),
    .last             (last),
    .board_error      (board_error),
    .status           (status),
    .filtered_input   (filtered_input),
    .fail_low_mask    (fail_low_mask),
    .fail_high_mask   (fail_high_mask),
    .chan_command     (chan_command),
    .chan_forcing     (chan_forcing),
    .chan_fail_enable (chan_fail_enable)
  );

  // Shadow of the board images
  logic [2:0] bcount;
  word_t      in_img   [BOARDS];
  word_t      out_img  [BOARDS];
  word_t      cmd      [BOARDS];
  word_t      frc_lo   [BOARDS];
  word_t      frc_hi   [BOARDS];
  word_t      flt_lo   [BOARDS];
  word_t      flt_hi   [BOARDS];
  word_t      fen      [BOARDS];
  word_t      rst_pend [BOARDS];
  word_t      last_rd  [BOARDS];
  word_t      last_f1  [BOARDS];
  logic [1:0] stat     [BOARDS];

  sup_result_t pending_results[$];
  stim_row_t   stim_rows[$];

  int n_items;
  int n_results;
  int n_writes;
  int n_rejects;
  int n_cfg;
  int n_live;
  int n_mism;
  int cycles;
  bit no_idle;

  initial begin
    clk = 1'b0;
  end
  always #6 clk = ~clk;

  initial begin
    bcount = '0;
    for (int b = 0; b < BOARDS; b++) begin
      in_img[b] = '0; out_img[b] = '0; cmd[b] = '0; frc_lo[b] = '0;
      frc_hi[b] = '0; flt_lo[b] = '0; flt_hi[b] = '0; fen[b] = '0;
      rst_pend[b] = '0; last_rd[b] = '0; last_f1[b] = '0; stat[b] = '0;
    end
  end

  // Snapshot of one board after an action
  function automatic sup_result_t board_view(logic [1:0] b, word_t cm, logic drv, logic lst);
    sup_result_t r;
    r.drv  = drv;
    r.word = out_img[b];
    r.lst  = lst;
    r.berr = 1'b0;
    r.stat = stat[b];
    r.filt = in_img[b];
    r.flo  = flt_lo[b];
    r.fhi  = flt_hi[b];
    r.ccmd = (cmd[b] & cm) != '0;
    r.cfrc = ((frc_hi[b] & cm) != '0) ? FRC_HIGH :
             ((frc_lo[b] & cm) != '0) ? FRC_LOW : FRC_NONE;
    r.cfen = (fen[b] & cm) != '0;
    return r;
  endfunction

  // Quiet or rejected result: everything zero but last (and the error flag)
  function automatic sup_result_t plain_result(logic is_err);
    sup_result_t r;
    r = '0;
    r.lst = 1'b1;
    r.berr = is_err;
    return r;
  endfunction

  task automatic output_update(logic [1:0] b);
    out_img[b] = ~rst_pend[b] & (cmd[b] | frc_hi[b]) & ~frc_lo[b];
    rst_pend[b] = '0;
  endtask

  task automatic arm_reset(logic [1:0] b, logic [31:0] m);
    rst_pend[b] = m[23:0] & CHAN_MASK;
    flt_lo[b] &= ~rst_pend[b];
    flt_hi[b] &= ~rst_pend[b];
    stat[b] &= ~ST_CHFAIL;
  endtask

  // Apply one accepted item to the shadow and queue the results it gives
  task automatic supervise(logic [3:0] act, logic [1:0] b, logic [4:0] ch,
                           logic [1:0] st, logic [31:0] rm, word_t rb);
    word_t cm;
    word_t f1;
    word_t pf;
    logic  quiet;
    quiet = 1'b1;
    if (b >= bcount || b >= BOARDS) begin
      pending_results.push_back(plain_result(1'b1));
    end else begin
      cm = (ch >= CH_FIRST && ch <= CH_LAST) ? (word_t'(1) << (ch + CH_BIT_OFS)) : '0;
      case (act)
        ACT_CMD: begin
          if (st != 2'd0) cmd[b] |= cm; else cmd[b] &= ~cm;
        end
        ACT_FORCE: begin
          if (st == SET_FORCE_LOW) frc_lo[b] |= cm; else frc_lo[b] &= ~cm;
          if (st == SET_FORCE_HIGH) frc_hi[b] |= cm; else frc_hi[b] &= ~cm;
        end
        ACT_FEN: begin
          if (st != 2'd0) fen[b] |= cm; else fen[b] &= ~cm;
        end
        ACT_RMASK: arm_reset(b, rm);
        ACT_DRIVE: begin
          output_update(b);
          pending_results.push_back(board_view(b, cm, 1'b1, 1'b1));
          quiet = 1'b0;
        end
        ACT_SAMPLE: begin
          // two-sample filter on the readback, then on the fail-to-1 flags
          in_img[b] = (in_img[b] & (rb | last_rd[b])) | (rb & last_rd[b]);
          last_rd[b] = rb;
          flt_lo[b] |= fen[b] & ~out_img[b] & ~in_img[b];
          f1 = fen[b] & out_img[b] & in_img[b];
          pf = last_f1[b];
          flt_hi[b] = (flt_hi[b] & (f1 | pf)) | (f1 & pf);
          last_f1[b] = f1;
          if (flt_lo[b] != '0 || flt_hi[b] != '0) stat[b] |= ST_CHFAIL;
          if (in_img[b][0]) stat[b] |= ST_SUPPLY;
        end
        ACT_LED: begin
          if (st != 2'd0) cmd[b] |= LED_BIT; else cmd[b] &= ~LED_BIT;
        end
        ACT_BRESET: begin
          // power off, then power on: two output writes
          in_img[b] = '0;
          out_img[b] = '0;
          arm_reset(b, RMASK_ALL);
          cmd[b] |= PWR_BIT;
          output_update(b);
          pending_results.push_back(board_view(b, cm, 1'b1, 1'b0));
          cmd[b] &= ~PWR_BIT;
          output_update(b);
          pending_results.push_back(board_view(b, cm, 1'b1, 1'b1));
          quiet = 1'b0;
        end
        default: ;
      endcase
      if (quiet) pending_results.push_back(board_view(b, cm, 1'b0, 1'b1));
    end
  endtask

  task automatic cmp_field(string name, logic [23:0] e, logic [23:0] a);
    if (e !== a) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      n_mism++;
    end
  endtask

  // Result check, board_count tracking and item acceptance
  always @(posedge clk) begin
    sup_result_t e;
    if (!rst) begin
      if (done) begin
        n_results++;
        if (drive_strobe) n_writes++;
        if (board_error) n_rejects++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with none expected, out_word %0h", $time, out_word);
          n_mism++;
        end else begin
          e = pending_results.pop_front();
          cmp_field("drive_strobe", 24'(e.drv), 24'(drive_strobe));
          cmp_field("out_word", e.word, out_word);
          cmp_field("last", 24'(e.lst), 24'(last));
          cmp_field("board_error", 24'(e.berr), 24'(board_error));
          cmp_field("status", 24'(e.stat), 24'(status));
          cmp_field("filtered_input", e.filt, filtered_input);
          cmp_field("fail_low_mask", e.flo, fail_low_mask);
          cmp_field("fail_high_mask", e.fhi, fail_high_mask);
          cmp_field("chan_command", 24'(e.ccmd), 24'(chan_command));
          cmp_field("chan_forcing", 24'(e.cfrc), 24'(chan_forcing));
          cmp_field("chan_fail_enable", 24'(e.cfen), 24'(chan_fail_enable));
        end
      end
      if (board_count_we) bcount = board_count_wdata;
      if (start && !busy) begin
        supervise(action, board, channel, setting, reset_mask, readback);
        if (offer_has_exp) pending_results[pending_results.size() - 1] = offer_exp;
        n_items++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item at a falling edge and hold it until taken
  task automatic send_item(logic [3:0] act, logic [1:0] b, logic [4:0] ch, logic [1:0] st,
                           logic [31:0] rm, word_t rb, logic has_exp, sup_result_t exp);
    int tgt;
    int gap;
    action = act; board = b; channel = ch; setting = st;
    reset_mask = rm; readback = rb;
    offer_has_exp = has_exp; offer_exp = exp;
    start = 1'b1;
    if (b < bcount && b < BOARDS) n_live++;
    tgt = n_items + 1;
    do @(negedge clk); while (n_items < tgt);
    gap = next_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_board_count(logic [2:0] v);
    drain();
    board_count_we = 1'b1;
    board_count_wdata = v;
    @(negedge clk);
    board_count_we = 1'b0;
    n_cfg++;
  endtask

  function automatic void add_row(logic [3:0] act, logic [1:0] b, logic [4:0] ch,
                                  logic [1:0] st, logic [31:0] rm, word_t rb);
    stim_row_t r;
    r = '0;
    r.act = act; r.brd = b; r.ch = ch; r.st = st; r.rm = rm; r.rb = rb;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_typed(logic [3:0] act, logic [1:0] b, logic [4:0] ch,
                                    sup_result_t exp);
    stim_row_t r;
    r = '0;
    r.act = act; r.brd = b; r.ch = ch;
    r.has_exp = 1'b1; r.exp = exp;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [2:0] v);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1; r.cfg = v;
    stim_rows.push_back(r);
  endfunction

  // Readback: random, close to what the board drives, a repeat, or its inverse
  function automatic word_t pick_readback(logic [1:0] b);
    int m;
    m = $urandom_range(0, 9);
    if (m < 3) return word_t'($urandom);
    if (m < 7) begin
      if ($urandom_range(0, 3) == 0) return out_img[b] ^ (word_t'(1) << $urandom_range(0, 23));
      return out_img[b];
    end
    if (m < 9) return last_rd[b];
    return ~out_img[b];
  endfunction

  function automatic logic [31:0] pick_rmask();
    int m;
    m = $urandom_range(0, 7);
    if (m == 0) return RMASK_ALL;
    if (m == 1) return '0;
    if (m == 2) return $urandom;
    return $urandom & $urandom & $urandom;
  endfunction

  // Enable, command, drive, then two readbacks: reaches the fail filters
  task automatic send_sequence(logic [1:0] b);
    logic [4:0] ch;
    word_t rb;
    ch = 5'($urandom_range(CH_FIRST, CH_LAST));
    send_item(ACT_FEN, b, ch, 2'($urandom_range(1, 3)), '0, '0, 1'b0, '0);
    send_item(ACT_CMD, b, ch, 2'($urandom), '0, '0, 1'b0, '0);
    send_item(ACT_DRIVE, b, ch, 2'($urandom), $urandom, word_t'($urandom), 1'b0, '0);
    rb = pick_readback(b);
    send_item(ACT_SAMPLE, b, ch, 2'($urandom), $urandom, rb, 1'b0, '0);
    send_item(ACT_SAMPLE, b, ch, 2'($urandom), $urandom, rb, 1'b0, '0);
  endtask

  task automatic send_random();
    int lim;
    int sel;
    logic [1:0] b;
    logic [3:0] act;
    logic [4:0] ch;
    lim = (bcount > BOARDS) ? BOARDS : bcount;
    if (lim != 0 && $urandom_range(0, 9) != 0) b = 2'($urandom_range(0, lim - 1));
    else b = 2'($urandom_range(0, 3));
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      send_sequence(b);
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 14) act = ACT_CMD;
      else if (sel < 26) act = ACT_FORCE;
      else if (sel < 40) act = ACT_FEN;
      else if (sel < 46) act = ACT_RMASK;
      else if (sel < 60) act = ACT_DRIVE;
      else if (sel < 80) act = ACT_SAMPLE;
      else if (sel < 85) act = ACT_LED;
      else if (sel < 89) act = ACT_QUERY;
      else if (sel < 95) act = ACT_BRESET;
      else act = 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      ch = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(CH_FIRST, CH_LAST));
      send_item(act, b, ch, 2'($urandom), pick_rmask(), pick_readback(b), 1'b0, '0);
    end
  endtask

  // Main sequence
  initial begin
    int phase_bc[7] = '{4, 1, 7, 0, 3, 2, 4};
    stim_row_t r;
    int goal;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_QUERY; board = '0; channel = '0; setting = '0;
    reset_mask = '0; readback = '0;
    board_count_we = 1'b0; board_count_wdata = '0;
    offer_has_exp = 1'b0; offer_exp = '0;
    n_items = 0; n_results = 0; n_writes = 0; n_rejects = 0;
    n_cfg = 0; n_live = 0; n_mism = 0; cycles = 0; no_idle = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed part: no boards after reset, then every action at the extremes
    add_typed(ACT_QUERY, 2'd0, 5'd1, plain_result(1'b1));
    add_typed(ACT_BRESET, 2'd3, 5'd19, plain_result(1'b1));
    add_cfg(3'd7);
    add_typed(ACT_QUERY, 2'd3, 5'd0, plain_result(1'b0));
    add_row(ACT_CMD, 2'd0, 5'd1, 2'd1, '0, '0);
    add_row(ACT_CMD, 2'd0, 5'd19, 2'd3, '0, '0);
    add_row(ACT_CMD, 2'd0, 5'd20, 2'd1, '0, '0);
    add_row(ACT_CMD, 2'd0, 5'd0, 2'd1, '0, '0);
    add_row(ACT_FORCE, 2'd0, 5'd2, SET_FORCE_LOW, '0, '0);
    add_row(ACT_FORCE, 2'd0, 5'd3, SET_FORCE_HIGH, '0, '0);
    add_row(ACT_FORCE, 2'd0, 5'd2, 2'd2, '0, '0);
    add_row(ACT_FEN, 2'd0, 5'd1, 2'd1, '0, '0);
    add_row(ACT_FEN, 2'd0, 5'd31, 2'd1, '0, '0);
    add_row(ACT_LED, 2'd0, 5'd1, 2'd1, '0, '0);
    add_row(ACT_RMASK, 2'd0, 5'd1, 2'd0, RMASK_ALL, '0);
    add_row(ACT_DRIVE, 2'd0, 5'd1, 2'd0, '0, '0);
    add_row(ACT_DRIVE, 2'd0, 5'd19, 2'd0, '0, '0);
    add_row(ACT_SAMPLE, 2'd0, 5'd1, 2'd0, '0, 24'hFFFFFF);
    add_row(ACT_SAMPLE, 2'd0, 5'd1, 2'd0, '0, 24'hFFFFFF);
    add_row(ACT_SAMPLE, 2'd0, 5'd19, 2'd0, '0, '0);
    add_row(ACT_SAMPLE, 2'd0, 5'd19, 2'd3, '0, '0);
    add_row(ACT_SPARE_LO, 2'd1, 5'd4, 2'd1, RMASK_ALL, 24'hFFFFFF);
    add_row(ACT_SPARE_HI, 2'd1, 5'd4, 2'd1, RMASK_ALL, 24'hFFFFFF);
    add_row(ACT_BRESET, 2'd0, 5'd1, 2'd0, '0, '0);
    add_cfg(3'd2);
    add_typed(ACT_QUERY, 2'd2, 5'd5, plain_result(1'b1));
    add_row(ACT_QUERY, 2'd1, 5'd5, 2'd0, '0, '0);
    add_row(ACT_FEN, 2'd1, 5'd19, 2'd0, '0, '0);

    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      if (r.is_cfg) set_board_count(r.cfg);
      else send_item(r.act, r.brd, r.ch, r.st, r.rm, r.rb, r.has_exp, r.exp);
    end

    // random phases over several board counts
    foreach (phase_bc[p]) begin
      set_board_count(3'(phase_bc[p]));
      no_idle = (p == 2) || ($urandom_range(0, 2) == 0);
      if (phase_bc[p] == 0) begin
        repeat (15) send_random();
      end else begin
        goal = n_live + PHASE_QUOTA;
        while (n_live < goal - PHASE_QUOTA / 2) send_random();
        drain();
        while (n_live < goal) send_random();
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Covered %0d items and %0d results over %0d board_count settings:",
             n_items, n_results, n_cfg);
    $display("%0d output writes, %0d rejected boards, %0d mismatching fields",
             n_writes, n_rejects, n_mism);
    if (n_mism == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/dos_pkg.sv
src/dos_front.sv
src/dos_back.sv
src/digital_output_supervisor.sv
src/dos_checker.sv
tb/tb_digital_output_supervisor.sv
